@@ rtl/lbwp_pkg.sv @@
// Shared types and constants for the LED bit waveform packer.
package lbwp_pkg;

  localparam int CFG_W = 6;
  localparam int CFG_ADDR_W = 2;
  localparam int BYTE_W = 8;
  localparam int MAX_SYMBOL_BITS_DEFAULT = 56;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ONE_HIGH   = 2'd0,
    REG_ONE_TOTAL  = 2'd1,
    REG_ZERO_HIGH  = 2'd2,
    REG_ZERO_TOTAL = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] one_high;
    logic [CFG_W-1:0] one_total;
    logic [CFG_W-1:0] zero_high;
    logic [CFG_W-1:0] zero_total;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    one_high:   6'd14,
    one_total:  6'd28,
    zero_high:  6'd7,
    zero_total: 6'd21
  };

  typedef struct packed {
    logic [CFG_W-1:0] high;
    logic [CFG_W-1:0] total;
    logic             item_end;
    logic             frame_last;
  } sym_cmd_t;

endpackage

@@ rtl/led_bit_waveform_packer.sv @@
// Top level of the LED bit waveform packer: configuration registers, front end, queue, back end.
// An input byte is registered in the front end and its symbol commands pass through the queue.
// The back end holds each finished byte until the next one or the end of the item decides its
// last flag. It loads one symbol command at a time and packs it into bytes before taking the
// next, then closes each item and, at the end of a frame, adds zero padding bytes.
// Reset: synchronous; clears the queue, the packing state and restores the register defaults.
module led_bit_waveform_packer #(
  parameter int MAX_SYMBOL_BITS = lbwp_pkg::MAX_SYMBOL_BITS_DEFAULT,
  parameter int QUEUE_DEPTH     = lbwp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lbwp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lbwp_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lbwp_pkg::BYTE_W-1:0]     color_byte,
  input  logic                            frame_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [lbwp_pkg::BYTE_W-1:0]     out_byte,
  output logic                            run_last,
  output logic                            is_padding
);
  import lbwp_pkg::*;

  cfg_t     cfg;
  logic     fq_valid;
  logic     fq_ready;
  sym_cmd_t fq_data;
  logic     qb_valid;
  logic     qb_ready;
  sym_cmd_t qb_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ONE_HIGH:   cfg.one_high   <= cfg_wdata;
        REG_ONE_TOTAL:  cfg.one_total  <= cfg_wdata;
        REG_ZERO_HIGH:  cfg.zero_high  <= cfg_wdata;
        REG_ZERO_TOTAL: cfg.zero_total <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lbwp_front #(
    .MAX_SYMBOL_BITS(MAX_SYMBOL_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .color_byte (color_byte),
    .frame_last (frame_last),
    .cmd_valid  (fq_valid),
    .cmd_ready  (fq_ready),
    .cmd        (fq_data)
  );

  lbwp_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_data  (qb_data)
  );

  lbwp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (qb_valid),
    .cmd_ready  (qb_ready),
    .cmd        (qb_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .is_padding (is_padding)
  );

endmodule

@@ rtl/lbwp_front.sv @@
// Front end: accepts colour bytes and turns each bit into a clamped symbol command.
module lbwp_front #(
  parameter int MAX_SYMBOL_BITS = lbwp_pkg::MAX_SYMBOL_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lbwp_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lbwp_pkg::BYTE_W-1:0]   color_byte,
  input  logic                          frame_last,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output lbwp_pkg::sym_cmd_t            cmd
);
  import lbwp_pkg::*;

  localparam logic [CFG_W-1:0] MaxBits = CFG_W'(MAX_SYMBOL_BITS);

  logic              busy;
  logic [BYTE_W-1:0] color;
  logic              last;
  logic [2:0]        idx;
  logic              bit_one;
  logic [CFG_W-1:0]  total_raw;
  logic [CFG_W-1:0]  high_raw;
  logic [CFG_W-1:0]  total_sat;
  logic              push;
  logic              accept;

  assign bit_one   = color[3'd7 - idx];
  assign total_raw = bit_one ? cfg.one_total : cfg.zero_total;
  assign high_raw  = bit_one ? cfg.one_high : cfg.zero_high;
  assign total_sat = (total_raw > MaxBits) ? MaxBits : total_raw;

  assign cmd_valid      = busy;
  assign cmd.total      = total_sat;
  assign cmd.high       = (high_raw > total_sat) ? total_sat : high_raw;
  assign cmd.item_end   = (idx == 3'd7);
  assign cmd.frame_last = last;

  assign push     = busy && cmd_ready;
  assign in_ready = !busy || (push && idx == 3'd7);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (accept) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (push) begin
      idx <= idx + 3'd1;
      if (idx == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      color <= color_byte;
      last  <= frame_last;
    end
  end

endmodule

@@ rtl/lbwp_queue.sv @@
// Short command queue between the front end and the packing back end.
module lbwp_queue #(
  parameter int DEPTH = lbwp_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  lbwp_pkg::sym_cmd_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output lbwp_pkg::sym_cmd_t rd_data
);
  import lbwp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  sym_cmd_t          mem [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_wr;
  logic              do_rd;

  assign wr_ready = (count != CntW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

@@ rtl/lbwp_back.sv @@
// Back end: packs symbol bits into bytes, holds one byte back to mark the last, pads frames.
module lbwp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  lbwp_pkg::sym_cmd_t          cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lbwp_pkg::BYTE_W-1:0] out_byte,
  output logic                        run_last,
  output logic                        is_padding
);
  import lbwp_pkg::*;

  typedef enum logic [2:0] {
    ST_SYM = 3'b001,
    ST_END = 3'b010,
    ST_PAD = 3'b100
  } state_t;

  function automatic logic [BYTE_W-1:0] run_mask(input logic [3:0] n);
    logic [BYTE_W:0] m;
    m = ((BYTE_W+1)'(1) << n) - (BYTE_W+1)'(1);
    return m[BYTE_W-1:0];
  endfunction

  state_t            state, state_next;
  logic              cur_valid, cur_valid_next;
  logic [CFG_W-1:0]  hi_rem, hi_rem_next;
  logic [CFG_W-1:0]  tot_rem, tot_rem_next;
  logic              cur_end, cur_end_next;
  logic              cur_flast, cur_flast_next;
  logic              pend_valid, pend_valid_next;
  logic [BYTE_W-1:0] pend, pend_next;
  logic [6:0]        acc, acc_next;
  logic [2:0]        fill, fill_next;
  logic [1:0]        count, count_next;

  logic [3:0]        room;
  logic [3:0]        take;
  logic [3:0]        h;
  logic              full;
  logic [BYTE_W-1:0] byte_v;
  logic              can_push;
  logic              push_en;
  logic [BYTE_W-1:0] push_byte;
  logic              push_last;
  logic              push_pad;

  assign room     = 4'd8 - {1'b0, fill};
  assign take     = (tot_rem < {2'b00, room}) ? tot_rem[3:0] : room;
  assign h        = (hi_rem < {2'b00, take}) ? hi_rem[3:0] : take;
  assign full     = (take == room);
  assign byte_v   = {1'b0, acc} | (run_mask(h) << fill);
  assign can_push = !out_valid || out_ready;

  always_comb begin
    state_next      = state;
    cur_valid_next  = cur_valid;
    hi_rem_next     = hi_rem;
    tot_rem_next    = tot_rem;
    cur_end_next    = cur_end;
    cur_flast_next  = cur_flast;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    acc_next        = acc;
    fill_next       = fill;
    count_next      = count;
    cmd_ready       = 1'b0;
    push_en         = 1'b0;
    push_byte       = '0;
    push_last       = 1'b0;
    push_pad        = 1'b0;
    unique case (state)
      ST_SYM: begin
        if (!cur_valid) begin
          cmd_ready = 1'b1;
          if (cmd_valid) begin
            cur_valid_next = 1'b1;
            hi_rem_next    = cmd.high;
            tot_rem_next   = cmd.total;
            cur_end_next   = cmd.item_end;
            cur_flast_next = cmd.frame_last;
          end
        end else if (!(full && pend_valid && !can_push)) begin
          if (full) begin
            if (pend_valid) begin
              push_en   = 1'b1;
              push_byte = pend;
            end
            pend_valid_next = 1'b1;
            pend_next       = byte_v;
            acc_next        = '0;
            fill_next       = '0;
            count_next      = count + 2'd1;
          end else begin
            acc_next  = byte_v[6:0];
            fill_next = fill + take[2:0];
          end
          hi_rem_next  = hi_rem - {2'b00, h};
          tot_rem_next = tot_rem - {2'b00, take};
          if (tot_rem == {2'b00, take}) begin
            cur_valid_next = 1'b0;
            if (cur_end) begin
              state_next = ST_END;
            end
          end
        end
      end
      ST_END: begin
        if (!pend_valid) begin
          state_next = cur_flast ? ST_PAD : ST_SYM;
        end else if (can_push) begin
          push_en         = 1'b1;
          push_byte       = pend;
          push_last       = !cur_flast;
          pend_valid_next = 1'b0;
          state_next      = cur_flast ? ST_PAD : ST_SYM;
        end
      end
      ST_PAD: begin
        if (can_push) begin
          push_en    = 1'b1;
          push_pad   = 1'b1;
          push_last  = (count == 2'd3);
          count_next = count + 2'd1;
          if (count == 2'd3) begin
            acc_next   = '0;
            fill_next  = '0;
            state_next = ST_SYM;
          end
        end
      end
      default: begin
        state_next = ST_SYM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SYM;
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
      acc        <= '0;
      fill       <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_valid  <= cur_valid_next;
      pend_valid <= pend_valid_next;
      acc        <= acc_next;
      fill       <= fill_next;
      count      <= count_next;
      if (push_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_rem    <= hi_rem_next;
    tot_rem   <= tot_rem_next;
    cur_end   <= cur_end_next;
    cur_flast <= cur_flast_next;
    pend      <= pend_next;
    if (push_en) begin
      out_byte   <= push_byte;
      run_last   <= push_last;
      is_padding <= push_pad;
    end
  end

endmodule

@@ rtl/lbwp_checker.sv @@
// Port-level checker for the LED bit waveform packer and its bind to the top level.
module lbwp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_we,
  input logic [lbwp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [lbwp_pkg::CFG_W-1:0]      cfg_wdata,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [lbwp_pkg::BYTE_W-1:0]     color_byte,
  input logic                            frame_last,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [lbwp_pkg::BYTE_W-1:0]     out_byte,
  input logic                            run_last,
  input logic                            is_padding
);

  // A stalled result keeps its payload until the transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last)
      && $stable(is_padding))
    else $error("stalled result changed");

  // Padding bytes are always zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_padding |-> out_byte == '0)
    else $error("padding byte not zero");

  // Reset leaves no result pending and the input side open.
  a_reset_clear: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid && in_ready)
    else $error("state not cleared by reset");

endmodule

bind led_bit_waveform_packer lbwp_checker u_checker (.*);
